// ===== hw/rtl/gss_pkg.sv =====
// Package for the generator swing step core: fixed-point constants,
// CORDIC arctangent table and a saturation helper. No dependencies.
`default_nettype none
package gss_pkg;
    localparam logic signed [31:0] Q_ONE = 32'sd16777216;
    localparam logic signed [31:0] Q_PI = 32'sd52707179;
    localparam logic signed [31:0] Q_HALF_PI = 32'sd26353589;
    localparam logic signed [31:0] Q_TWO_PI = 32'sd105414357;
    localparam logic signed [31:0] CORDIC_GAIN = 32'sd10188014;
    localparam logic signed [9:0] SYNC_SPEED = 10'sd314;
    localparam int CORDIC_ITERS = 24;

    // register indexes
    localparam logic [2:0] REG_MECH = 3'd0;
    localparam logic [2:0] REG_EMF = 3'd1;
    localparam logic [2:0] REG_INERT = 3'd2;
    localparam logic [2:0] REG_STEP = 3'd3;
    localparam logic [2:0] REG_REACT = 3'd4;
    localparam logic [2:0] REG_ANGLE = 3'd5;

    function automatic logic signed [31:0] atan_lut(input logic [4:0] i);
        logic signed [31:0] v;
        case (i)
            5'd0: v = 32'sd13176795;
            5'd1: v = 32'sd7778716;
            5'd2: v = 32'sd4110060;
            5'd3: v = 32'sd2086331;
            5'd4: v = 32'sd1047214;
            5'd5: v = 32'sd524117;
            5'd6: v = 32'sd262123;
            5'd7: v = 32'sd131069;
            default: v = (i < 5'd24) ? (32'sd1 <<< (5'd24 - i)) : 32'sd0;
        endcase
        return v;
    endfunction

    // saturate a 66-bit signed value to 32 bits
    function automatic logic signed [31:0] sat66(input logic signed [65:0] v);
        logic signed [31:0] r;
        if (v > 66'sh7FFFFFFF) r = 32'sh7FFFFFFF;
        else if (v < -66'sh80000000) r = 32'sh80000000;
        else r = v[31:0];
        return r;
    endfunction
endpackage
`default_nettype wire

// ===== hw/rtl/generator_swing_step_core.sv =====
// Top level of the generator swing step core: APB registers, stream ports
// and a sequencer around one shared 33x33 multiplier.
// Depends on gss_pkg.
`default_nettype none
// A step item passes from accept to m_tvalid through 6 update steps,
// 7 angle reduction steps, 24 CORDIC iterations, 9 output steps and
// 1 output load; a restart passes through the restart step and the output load.
// One item at a time: s_tready is low while an item is in work or an
// unaccepted result is pending.
// Reset (rst_n, async low) loads speed 1.0, angle 0, power 0.
module generator_swing_step_core
    import gss_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // tdata: volt_re[31:0], volt_im[63:32], step_mult[71:64]
    input  wire logic [71:0] s_tdata,
    // tuser: restart
    input  wire logic        s_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // tdata: inj_re, inj_im, rotor_angle, rotor_speed, elec_power (32 each)
    output logic [159:0]     m_tdata
);
    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001, S_MUL = 7'b0000010, S_RED = 7'b0000100,
        S_COR = 7'b0001000, S_POST = 7'b0010000, S_OUT = 7'b0100000,
        S_RST = 7'b1000000
    } state_t;

    state_t state_reg;
    logic [4:0] step_reg;
    logic signed [31:0] mech_reg, ang0_reg;
    logic [30:0] emf_reg, inert_reg, tstep_reg, react_reg;
    logic signed [31:0] speed_reg, angle_reg, power_reg;
    logic signed [31:0] ur_reg, ui_reg;
    logic [7:0] n_reg;
    logic signed [31:0] g_reg, t1_reg, t2_reg, w1_reg;
    logic signed [31:0] cx_reg, cy_reg, cr_reg;
    logic signed [32:0] red_reg;
    logic signed [65:0] pacc_reg;
    logic neg_reg;
    logic signed [31:0] er_reg, ei_reg, jr_reg, ji_reg;
    logic [159:0] out_reg;

    // APB
    logic wr_en;
    assign pready = 1'b1;
    assign wr_en = psel && penable && pwrite;
    always_comb
    begin
        unique case (paddr[4:2])
            REG_MECH:  prdata = mech_reg;
            REG_EMF:   prdata = {1'b0, emf_reg};
            REG_INERT: prdata = {1'b0, inert_reg};
            REG_STEP:  prdata = {1'b0, tstep_reg};
            REG_REACT: prdata = {1'b0, react_reg};
            REG_ANGLE: prdata = ang0_reg;
            default:   prdata = 32'd0;
        endcase
    end
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mech_reg <= '0; emf_reg <= '0; inert_reg <= '0;
            tstep_reg <= 31'd1677722; react_reg <= '0; ang0_reg <= '0;
        end
        else if (wr_en)
        begin
            unique case (paddr[4:2])
                REG_MECH:  mech_reg <= pwdata;
                REG_EMF:   emf_reg <= pwdata[30:0];
                REG_INERT: inert_reg <= pwdata[30:0];
                REG_STEP:  tstep_reg <= pwdata[30:0];
                REG_REACT: react_reg <= pwdata[30:0];
                REG_ANGLE: ang0_reg <= pwdata;
                default: ;
            endcase
        end
    end

    // shared multiplier: product >> sh (floor), operands chosen per step
    logic signed [32:0] ma, mb;
    logic signed [65:0] prod, pshift;
    logic [4:0] msh;
    logic signed [31:0] mres;
    assign prod = ma * mb;
    assign pshift = prod >>> msh;
    assign mres = sat66(pshift);

    always_comb
    begin
        ma = '0; mb = '0; msh = 5'd24;
        case (step_reg)
            5'd0: begin ma = {2'b0, tstep_reg}; mb = {25'd0, n_reg}; msh = 5'd0; end
            5'd1: begin ma = 33'(g_reg); mb = {2'b0, inert_reg}; end
            5'd2: begin ma = 33'(t1_reg); mb = 33'(t2_reg); end
            5'd4: begin ma = 33'(t1_reg); mb = 33'(SYNC_SPEED); msh = 5'd0; end
            5'd5: begin ma = 33'(t1_reg); mb = 33'(g_reg); end
            5'd7: begin ma = {2'b0, emf_reg}; mb = 33'(cx_reg); end
            5'd8: begin ma = {2'b0, emf_reg}; mb = 33'(cy_reg); end
            5'd9: begin ma = {2'b0, react_reg}; mb = 33'(ei_reg); end
            5'd10: begin ma = {2'b0, react_reg}; mb = 33'(er_reg); end
            5'd11: begin ma = {2'b0, react_reg}; mb = 33'(ui_reg); end
            5'd12: begin ma = {2'b0, react_reg}; mb = 33'(ur_reg); end
            5'd13: begin ma = 33'(ur_reg); mb = 33'(t1_reg); end
            5'd14: begin ma = 33'(ui_reg); mb = 33'(t2_reg); end
            default: ;
        endcase
    end

    // CORDIC step terms
    logic signed [31:0] dx, dy, at;
    assign dx = cy_reg >>> step_reg;
    assign dy = cx_reg >>> step_reg;
    assign at = atan_lut(step_reg);

    assign s_tready = (state_reg == S_IDLE) && (!m_tvalid || m_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE; step_reg <= '0; m_tvalid <= 1'b0;
            speed_reg <= Q_ONE; angle_reg <= '0; power_reg <= '0;
        end
        else
        begin
            if (m_tvalid && m_tready && state_reg != S_OUT) m_tvalid <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                    if (s_tvalid && s_tready)
                    begin
                        ur_reg <= s_tdata[31:0]; ui_reg <= s_tdata[63:32];
                        n_reg <= s_tdata[71:64]; step_reg <= '0;
                        state_reg <= s_tuser ? S_RST : S_MUL;
                    end
                S_RST:
                begin
                    speed_reg <= Q_ONE; angle_reg <= ang0_reg; power_reg <= mech_reg;
                    out_reg <= {mech_reg, Q_ONE, ang0_reg, 64'd0};
                    state_reg <= S_OUT;
                end
                S_MUL:
                begin
                    step_reg <= step_reg + 5'd1;
                    case (step_reg)
                        5'd0: g_reg <= mres;
                        5'd1:
                        begin
                            t1_reg <= mres;
                            t2_reg <= sat66(66'(mech_reg) - 66'(power_reg));
                        end
                        5'd2: w1_reg <= sat66(66'(speed_reg) + 66'(mres));
                        5'd3: t1_reg <= sat66(((66'(speed_reg) + 66'(w1_reg)) >>> 1)
                                                - 66'(Q_ONE));
                        5'd4: t1_reg <= mres;
                        5'd5:
                        begin
                            speed_reg <= w1_reg;
                            angle_reg <= sat66(66'(angle_reg) + 66'(mres));
                            state_reg <= S_RED;
                        end
                        default: ;
                    endcase
                end
                S_RED:
                begin
                    // angle mod 2*pi by compare and subtract on the magnitude,
                    // then fold to [-pi/2, pi/2]
                    logic signed [32:0] r;
                    logic signed [32:0] tp;
                    r = '0;
                    tp = 33'(Q_TWO_PI) <<< (5'd11 - step_reg);
                    if (step_reg == 5'd6)
                    begin
                        red_reg <= angle_reg[31] ? -33'(angle_reg) : 33'(angle_reg);
                        step_reg <= step_reg + 5'd1;
                    end
                    else if (step_reg != 5'd12)
                    begin
                        if (red_reg >= tp) red_reg <= red_reg - tp;
                        step_reg <= step_reg + 5'd1;
                    end
                    else
                    begin
                        r = angle_reg[31] ? -red_reg : red_reg;
                        if (r > 33'(Q_PI)) r = r - 33'(Q_TWO_PI);
                        if (r < -33'(Q_PI)) r = r + 33'(Q_TWO_PI);
                        neg_reg <= 1'b0;
                        if (r > 33'(Q_HALF_PI)) begin r = r - 33'(Q_PI); neg_reg <= 1'b1; end
                        else if (r < -33'(Q_HALF_PI)) begin r = r + 33'(Q_PI); neg_reg <= 1'b1; end
                        cr_reg <= r[31:0]; cx_reg <= CORDIC_GAIN; cy_reg <= '0;
                        step_reg <= '0; state_reg <= S_COR;
                    end
                end
                S_COR:
                begin
                    if (!cr_reg[31])
                    begin
                        cx_reg <= cx_reg - dx; cy_reg <= cy_reg + dy; cr_reg <= cr_reg - at;
                    end
                    else
                    begin
                        cx_reg <= cx_reg + dx; cy_reg <= cy_reg - dy; cr_reg <= cr_reg + at;
                    end
                    step_reg <= step_reg + 5'd1;
                    if (step_reg == 5'(CORDIC_ITERS - 1)) state_reg <= S_POST;
                end
                S_POST:
                begin
                    if (step_reg == 5'(CORDIC_ITERS))
                    begin
                        if (neg_reg) begin cx_reg <= -cx_reg; cy_reg <= -cy_reg; end
                        step_reg <= 5'd7;
                    end
                    else
                    begin
                        step_reg <= step_reg + 5'd1;
                        case (step_reg)
                            5'd7: er_reg <= mres;
                            5'd8: ei_reg <= mres;
                            5'd9: jr_reg <= mres;
                            5'd10: ji_reg <= sat66(-66'(mres));
                            5'd11: t1_reg <= sat66(66'(jr_reg) - 66'(mres));
                            5'd12: t2_reg <= sat66(66'(ji_reg) + 66'(mres));
                            5'd13: pacc_reg <= pshift;
                            5'd14:
                            begin
                                logic signed [31:0] p;
                                p = sat66(pacc_reg + pshift);
                                power_reg <= p;
                                out_reg <= {p, speed_reg, angle_reg, ji_reg, jr_reg};
                                state_reg <= S_OUT;
                            end
                            default: ;
                        endcase
                    end
                end
                S_OUT:
                    if (!m_tvalid || m_tready)
                    begin
                        m_tvalid <= 1'b1; state_reg <= S_IDLE;
                    end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
    assign m_tdata = out_reg;

    // state encoding and handshake checks
    a_one_hot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg)) else $error("state not one-hot");
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> !s_tready) else $error("ready while busy");
    a_out_after: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_OUT && (!m_tvalid || m_tready)) |=> m_tvalid)
        else $error("result lost");
endmodule
`default_nettype wire

// ===== tb/sv/tb_generator_swing_step_core.sv =====
// Self-checking testbench for generator_swing_step_core: APB register setup,
// stream stimulus with random idling and a bit-exact swing-step predictor.
// Depends on gss_pkg and the generator_swing_step_core RTL.
`timescale 1ns / 100ps
module tb_generator_swing_step_core;
    import gss_pkg::*;

    localparam int IDLE_LIMIT = 4000;
    localparam int SETTLE_CYCLES = 60;

    typedef struct {
        logic [31:0] inj_re;
        logic [31:0] inj_im;
        logic [31:0] angle;
        logic [31:0] speed;
        logic [31:0] power;
    } gen_result_t;

    logic         clk;
    logic         rst_n;
    logic         psel;
    logic         penable;
    logic         pwrite;
    logic [4:0]   paddr;
    logic [31:0]  pwdata;
    logic [31:0]  prdata;
    logic         pready;
    logic         s_tvalid;
    logic         s_tready;
    logic [71:0]  s_tdata;   // volt_re[31:0], volt_im[63:32], step_mult[71:64]
    logic         s_tuser;   // restart
    logic         m_tvalid;
    logic         m_tready;
    logic [159:0] m_tdata;   // inj_re, inj_im, rotor_angle, rotor_speed, elec_power

    // predictor copy of registers and machine state
    longint cfg_mech, cfg_emf, cfg_inertia, cfg_step, cfg_react, cfg_init_angle;
    longint gen_speed, gen_angle, gen_power;

    gen_result_t expected_results[$];
    int          error_count;
    int          idle_cycles;
    int          send_idle_pct;
    int          recv_stall_pct;

    generator_swing_step_core DUT (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // ---------------- predictor ----------------
    function automatic longint sat32(input longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint qmul(input longint a, input longint b);
        return sat32((a * b) >>> 24);
    endfunction

    function automatic void rotor_sincos(input longint a, output longint s,
                                         output longint c);
        longint r, x, y, dx, dy, atan_step;
        bit     flip;
        r = a % longint'(Q_TWO_PI);
        flip = 1'b0;
        x = longint'(CORDIC_GAIN);
        y = 0;
        if (r > longint'(Q_PI)) r -= longint'(Q_TWO_PI);
        if (r < -longint'(Q_PI)) r += longint'(Q_TWO_PI);
        if (r > longint'(Q_HALF_PI))
        begin
            r -= longint'(Q_PI);
            flip = 1'b1;
        end
        else if (r < -longint'(Q_HALF_PI))
        begin
            r += longint'(Q_PI);
            flip = 1'b1;
        end
        for (int i = 0; i < CORDIC_ITERS; i++)
        begin
            case (i)
                0: atan_step = 13176795;
                1: atan_step = 7778716;
                2: atan_step = 4110060;
                3: atan_step = 2086331;
                4: atan_step = 1047214;
                5: atan_step = 524117;
                6: atan_step = 262123;
                7: atan_step = 131069;
                default: atan_step = 64'sd1 << (24 - i);
            endcase
            dx = y >>> i;
            dy = x >>> i;
            if (r >= 0)
            begin
                x -= dx;
                y += dy;
                r -= atan_step;
            end
            else
            begin
                x += dx;
                y -= dy;
                r += atan_step;
            end
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
    endfunction

    // advance the generator state by one beat, return the expected result
    function automatic gen_result_t swing_step(input bit restart, input logic [31:0] vr,
                                               input logic [31:0] vi, input logic [7:0] n);
        gen_result_t res;
        longint ur, ui, g, gain, diff, w1, dev, rate, s, c, er, ei;
        longint inj_re, inj_im, ig_re, ig_im;
        inj_re = 0;
        inj_im = 0;
        if (restart)
        begin
            gen_speed = longint'(Q_ONE);
            gen_angle = cfg_init_angle;
            gen_power = cfg_mech;
        end
        else
        begin
            ur = longint'($signed(vr));
            ui = longint'($signed(vi));
            g = sat32(cfg_step * longint'(n));
            gain = qmul(g, cfg_inertia);
            diff = sat32(cfg_mech - gen_power);
            w1 = sat32(gen_speed + qmul(gain, diff));
            dev = sat32(((gen_speed + w1) >>> 1) - longint'(Q_ONE));
            rate = sat32(dev * 314);
            gen_speed = w1;
            gen_angle = sat32(gen_angle + qmul(rate, g));
            rotor_sincos(gen_angle, s, c);
            er = qmul(cfg_emf, c);
            ei = qmul(cfg_emf, s);
            inj_re = qmul(cfg_react, ei);
            inj_im = sat32(-qmul(cfg_react, er));
            ig_re = sat32(inj_re - qmul(cfg_react, ui));
            ig_im = sat32(inj_im + qmul(cfg_react, ur));
            gen_power = sat32(((ur * ig_re) >>> 24) + ((ui * ig_im) >>> 24));
        end
        res.inj_re = inj_re[31:0];
        res.inj_im = inj_im[31:0];
        res.angle = gen_angle[31:0];
        res.speed = gen_speed[31:0];
        res.power = gen_power[31:0];
        return res;
    endfunction

    // ---------------- checking ----------------
    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t mismatch %s: got %0d expected %0d", $time, what,
                 $signed(got), $signed(want));
        error_count++;
    endtask

    always @(posedge clk)
    begin
        gen_result_t want;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                if (expected_results.size() == 0)
                begin
                    $display("%0t unexpected result beat", $time);
                    error_count++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (m_tdata[31:0] !== want.inj_re)
                        report_mismatch("inj_re", m_tdata[31:0], want.inj_re);
                    if (m_tdata[63:32] !== want.inj_im)
                        report_mismatch("inj_im", m_tdata[63:32], want.inj_im);
                    if (m_tdata[95:64] !== want.angle)
                        report_mismatch("rotor_angle", m_tdata[95:64], want.angle);
                    if (m_tdata[127:96] !== want.speed)
                        report_mismatch("rotor_speed", m_tdata[127:96], want.speed);
                    if (m_tdata[159:128] !== want.power)
                        report_mismatch("elec_power", m_tdata[159:128], want.power);
                end
            end
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // watchdog: cycles with no beat on any port
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // ---------------- drivers ----------------
    task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        case (idx)
            REG_MECH:  cfg_mech = longint'($signed(value));
            REG_EMF:   cfg_emf = longint'(value[30:0]);
            REG_INERT: cfg_inertia = longint'(value[30:0]);
            REG_STEP:  cfg_step = longint'(value[30:0]);
            REG_REACT: cfg_react = longint'(value[30:0]);
            REG_ANGLE: cfg_init_angle = longint'($signed(value));
            default: ;
        endcase
    endtask

    task automatic send_item(input bit restart, input logic [31:0] vr,
                             input logic [31:0] vi, input logic [7:0] n);
        int gap;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct) gap++;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= restart;
        s_tdata <= {n, vi, vr};
        do @(posedge clk); while (!(s_tvalid && s_tready));
        expected_results.push_back(swing_step(restart, vr, vi, n));
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic load_machine(input logic [31:0] mech, input logic [31:0] emf,
                                input logic [31:0] inertia, input logic [31:0] tstep,
                                input logic [31:0] react, input logic [31:0] init_ang);
        write_reg(REG_MECH, mech);
        write_reg(REG_EMF, emf);
        write_reg(REG_INERT, inertia);
        write_reg(REG_STEP, tstep);
        write_reg(REG_REACT, react);
        write_reg(REG_ANGLE, init_ang);
    endtask

    function automatic logic [31:0] rand_volt();
        if ($urandom_range(9) == 0) return $urandom;
        return $urandom_range(32'h0400_0000) - 32'h0200_0000;
    endfunction

    function automatic logic [7:0] rand_mult();
        if ($urandom_range(9) == 0) return $urandom_range(255);
        return $urandom_range(1, 4);
    endfunction

    // ---------------- tests ----------------
    task automatic test_reset_state();
        // defaults after reset: zero power, emf and reactance
        send_item(1'b0, 32'h0100_0000, 32'h0, 8'd1);
        send_item(1'b0, 32'h7FFF_FFFF, 32'h8000_0000, 8'd255);
        wait_idle();
    endtask

    task automatic test_directed();
        load_machine(32'h00CC_CCCD, 32'h011A_E148, 32'h0019_999A, 32'h0002_8F5C,
                     32'h0350_0000, 32'h0080_0000);
        write_reg(3'd6, 32'hFFFF_FFFF);   // unmapped, ignored
        write_reg(3'd7, 32'h1234_5678);
        send_item(1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'd0);
        send_item(1'b0, 32'h0100_0000, 32'h0, 8'd1);
        send_item(1'b0, 32'h00F0_0000, 32'h0010_0000, 8'd0);   // zero multiplier
        send_item(1'b0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 8'd1);
        send_item(1'b0, 32'h8000_0000, 32'h8000_0000, 8'd1);
        send_item(1'b0, 32'h7FFF_FFFF, 32'h8000_0000, 8'd255);
        send_item(1'b0, 32'h0, 32'h0, 8'd128);
        send_item(1'b0, 32'hFFFF_FFFF, 32'h0000_0001, 8'd2);
        send_item(1'b1, 32'h0, 32'h0, 8'd5);
        wait_idle();
        // extreme registers: huge steps saturate angle and speed
        load_machine(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                     32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_item(1'b1, 32'h0, 32'h0, 8'd1);
        for (int i = 0; i < 4; i++)
            send_item(1'b0, $urandom, $urandom, 8'd255);
        wait_idle();
        load_machine(32'h8000_0000, 32'h0, 32'h0, 32'h0, 32'h0, 32'h8000_0000);
        send_item(1'b1, 32'h0, 32'h0, 8'd1);
        send_item(1'b0, 32'h0100_0000, 32'h0, 8'd255);
        send_item(1'b0, 32'h8000_0000, 32'h7FFF_FFFF, 8'd1);
        wait_idle();
    endtask

    task automatic test_random_phase(input int idle_pct, input int stall_pct,
                                     input int count);
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        if ($urandom_range(3) == 0)
            load_machine($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
        else
            load_machine($urandom_range(32'h0200_0000) - 32'h0100_0000,
                         $urandom_range(32'h0180_0000), $urandom_range(32'h0080_0000),
                         $urandom_range(32'h0040_0000), $urandom_range(32'h0600_0000),
                         $urandom_range(32'h0300_0000) - 32'h0180_0000);
        send_item(1'b1, $urandom, $urandom, $urandom_range(255));
        for (int i = 0; i < count; i++)
        begin
            // quiet stretch without idling inside each phase
            if (i == count / 2)
            begin
                send_idle_pct = 0;
                recv_stall_pct = 0;
            end
            else if (i == count / 2 + 20)
            begin
                send_idle_pct = idle_pct;
                recv_stall_pct = stall_pct;
            end
            if ($urandom_range(19) == 0)
                send_item(1'b1, $urandom, $urandom, $urandom_range(255));
            else
                send_item(1'b0, rand_volt(), rand_volt(), rand_mult());
        end
        wait_idle();
    endtask

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = 1'b0;
        m_tready = 1'b0;
        error_count = 0;
        idle_cycles = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        cfg_mech = 0;
        cfg_emf = 0;
        cfg_inertia = 0;
        cfg_step = 1677722;
        cfg_react = 0;
        cfg_init_angle = 0;
        gen_speed = longint'(Q_ONE);
        gen_angle = 0;
        gen_power = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_state();
        test_directed();
        test_random_phase(0, 0, 230);
        test_random_phase(74, 0, 230);
        test_random_phase(0, 74, 230);
        test_random_phase(6, 6, 230);

        if (error_count == 0 && expected_results.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule

// ===== sim.f =====
hw/rtl/gss_pkg.sv
hw/rtl/generator_swing_step_core.sv
tb/sv/tb_generator_swing_step_core.sv
